/* hdl/closest_point_on_segment_defines.svh */
// Assertion macros used by the checker file of the closest point block.
`ifndef CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CPS_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CPS_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

/* hdl/cps_pkg.sv */
// Package with widths, item types and region codes of the closest point block.
`timescale 1ns / 1ps

package cps_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int OUT_BITS = 32;
  localparam int DW  = COORD_BITS + 1;              // coordinate difference
  localparam int PW  = 2 * DW;                      // product of two differences
  localparam int SW  = PW + 1;                      // sum of two products
  localparam int LW  = 2 * COORD_BITS + 1;          // squared segment length
  localparam int QW  = COORD_BITS + FRAC_BITS;      // quotient bits
  localparam int NW  = COORD_BITS + LW + FRAC_BITS; // dividend bits
  localparam int WW  = 64;                          // final add width

  typedef enum logic [1:0] {
    RegionInterior = 2'd0,
    RegionStart    = 2'd1,
    RegionEnd      = 2'd2,
    RegionZero     = 2'd3
  } region_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] foot_x;
    logic signed [OUT_BITS-1:0] foot_y;
    logic [1:0]                 region;
  } out_t;

  // Side information that travels with an item through the pipeline.
  typedef struct packed {
    logic                         valid;
    region_e                      region;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } meta_t;

endpackage

/* hdl/cps_div.sv */
// Pipelined restoring divider, two dividends over one divisor, one bit per stage.
`timescale 1ns / 1ps

module cps_div import cps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [NW-1:0] num_x_i,
  input  logic [NW-1:0] num_y_i,
  input  logic [LW-1:0] den_i,
  input  meta_t         meta_i,
  output logic [QW-1:0] quo_x_o,
  output logic [QW-1:0] quo_y_o,
  output meta_t         meta_o
);

  typedef struct packed {
    logic [LW-1:0] rem;
    logic [QW-1:0] acc;
  } lane_t;

  function automatic lane_t div_step(lane_t s, logic [LW-1:0] den);
    logic [LW:0] t;
    logic [LW:0] diff;
    lane_t       r;
    t    = {s.rem, s.acc[QW-1]};
    diff = t - {1'b0, den};
    r.acc = {s.acc[QW-2:0], (t >= {1'b0, den})};
    r.rem = (t >= {1'b0, den}) ? diff[LW-1:0] : t[LW-1:0];
    return r;
  endfunction

  lane_t         x_q [QW];
  lane_t         y_q [QW];
  logic [LW-1:0] den_q [QW];
  meta_t         meta_q [QW];

  lane_t x_init, y_init;
  assign x_init = '{rem: num_x_i[NW-1 -: LW], acc: num_x_i[QW-1:0]};
  assign y_init = '{rem: num_y_i[NW-1 -: LW], acc: num_y_i[QW-1:0]};

  for (genvar i = 0; i < QW; i++) begin : g_stage
    lane_t         x_src, y_src;
    logic [LW-1:0] den_src;
    meta_t         meta_src;

    if (i == 0) begin : g_first
      assign x_src    = x_init;
      assign y_src    = y_init;
      assign den_src  = den_i;
      assign meta_src = meta_i;
    end else begin : g_rest
      assign x_src    = x_q[i-1];
      assign y_src    = y_q[i-1];
      assign den_src  = den_q[i-1];
      assign meta_src = meta_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]   <= div_step(x_src, den_src);
        y_q[i]   <= div_step(y_src, den_src);
        den_q[i] <= den_src;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[i] <= '0;
      end else if (en_i) begin
        meta_q[i] <= meta_src;
      end
    end
  end

  assign quo_x_o = x_q[QW-1].acc;
  assign quo_y_o = y_q[QW-1].acc;
  assign meta_o  = meta_q[QW-1];

endmodule

/* hdl/closest_point_on_segment.sv */
// Top level of the closest point on a line segment pipeline.
`timescale 1ns / 1ps

// Closest point on a segment. Each item carries a query point P and a segment
// from A to B; the block returns the point of the segment nearest to P in
// signed Q16.16 together with a region code: interior, clamped to the start,
// clamped to the end, or a zero-length segment (which returns A). Interior
// points are A + AB * dot(AP,AB) / |AB|^2 with the quotient truncated toward
// zero and computed exactly. The block accepts one item in every cycle in
// which the pipeline advances and delivers one result per item in order.
// It has four stages for the differences, the products, the dot products
// with the region test, and the dividend product, then one stage per
// quotient bit in the pipelined divider, then the output register. The
// whole pipeline advances together whenever the output register is empty
// or its result is being taken, so in_ready_o follows out_ready_i.
module closest_point_on_segment import cps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: coordinate differences.
  meta_t                s1_meta_d, s1_meta_q;
  logic                 s1_zero_d, s1_zero_q;
  logic signed [DW-1:0] apx_d, apy_d, bpx_d, bpy_d, dx_d, dy_d;
  logic signed [DW-1:0] apx_q, apy_q, bpx_q, bpy_q, dx_q, dy_q;

  always_comb begin
    apx_d = DW'(in_data_i.point_x) - DW'(in_data_i.start_x);
    apy_d = DW'(in_data_i.point_y) - DW'(in_data_i.start_y);
    bpx_d = DW'(in_data_i.end_x) - DW'(in_data_i.point_x);
    bpy_d = DW'(in_data_i.end_y) - DW'(in_data_i.point_y);
    dx_d  = DW'(in_data_i.end_x) - DW'(in_data_i.start_x);
    dy_d  = DW'(in_data_i.end_y) - DW'(in_data_i.start_y);
    s1_zero_d = (in_data_i.end_x == in_data_i.start_x) &&
                (in_data_i.end_y == in_data_i.start_y);
    s1_meta_d.valid  = in_valid_i;
    s1_meta_d.region = RegionInterior;
    s1_meta_d.neg_x  = dx_d[DW-1];
    s1_meta_d.neg_y  = dy_d[DW-1];
    s1_meta_d.ax     = in_data_i.start_x;
    s1_meta_d.ay     = in_data_i.start_y;
    s1_meta_d.bx     = in_data_i.end_x;
    s1_meta_d.by     = in_data_i.end_y;
  end

  // Stage 2: the six products and the magnitudes of the segment direction.
  meta_t                    s2_meta_q;
  logic                     s2_zero_q;
  logic signed [PW-1:0]     p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic [COORD_BITS-1:0]    magx_d, magy_d, s2_magx_q, s2_magy_q;
  logic signed [DW-1:0]     negx, negy;

  always_comb begin
    negx   = -dx_q;
    negy   = -dy_q;
    magx_d = dx_q[DW-1] ? negx[COORD_BITS-1:0] : dx_q[COORD_BITS-1:0];
    magy_d = dy_q[DW-1] ? negy[COORD_BITS-1:0] : dy_q[COORD_BITS-1:0];
  end

  // Stage 3: dot products, squared length and the region decision.
  meta_t                 s3_meta_d, s3_meta_q;
  logic signed [SW-1:0]  d1_d, d2_d;
  logic [LW-1:0]         len2_d, s3_len2_q, s3_d1_q;
  logic [COORD_BITS-1:0] s3_magx_q, s3_magy_q;

  always_comb begin
    d1_d   = SW'(p1_q) + SW'(p2_q);
    d2_d   = SW'(p3_q) + SW'(p4_q);
    len2_d = p5_q[LW-1:0] + p6_q[LW-1:0];
    s3_meta_d = s2_meta_q;
    if (s2_zero_q) begin
      s3_meta_d.region = RegionZero;
    end else if (d1_d[SW-1]) begin
      s3_meta_d.region = RegionStart;
    end else if (d2_d[SW-1]) begin
      s3_meta_d.region = RegionEnd;
    end else begin
      s3_meta_d.region = RegionInterior;
    end
  end

  // Stage 4: dividends |AB| * d1 scaled by the fraction bits.
  meta_t                      s4_meta_q;
  logic [NW-1:0]              s4_num_x_q, s4_num_y_q;
  logic [LW-1:0]              s4_den_q;
  logic [COORD_BITS+LW-1:0]   prod_x, prod_y;

  assign prod_x = (COORD_BITS+LW)'(s3_magx_q) * (COORD_BITS+LW)'(s3_d1_q);
  assign prod_y = (COORD_BITS+LW)'(s3_magy_q) * (COORD_BITS+LW)'(s3_d1_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      apx_q <= apx_d;
      apy_q <= apy_d;
      bpx_q <= bpx_d;
      bpy_q <= bpy_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      s1_zero_q <= s1_zero_d;

      p1_q <= PW'(apx_q) * PW'(dx_q);
      p2_q <= PW'(apy_q) * PW'(dy_q);
      p3_q <= PW'(bpx_q) * PW'(dx_q);
      p4_q <= PW'(bpy_q) * PW'(dy_q);
      p5_q <= PW'(dx_q) * PW'(dx_q);
      p6_q <= PW'(dy_q) * PW'(dy_q);
      s2_magx_q <= magx_d;
      s2_magy_q <= magy_d;
      s2_zero_q <= s1_zero_q;

      // Interior items have 0 <= d1 <= len2, so d1 fits the length width.
      s3_d1_q   <= d1_d[LW-1:0];
      s3_len2_q <= len2_d;
      s3_magx_q <= s2_magx_q;
      s3_magy_q <= s2_magy_q;

      s4_num_x_q <= {prod_x, {FRAC_BITS{1'b0}}};
      s4_num_y_q <= {prod_y, {FRAC_BITS{1'b0}}};
      s4_den_q   <= s3_len2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_meta_q <= '0;
      s2_meta_q <= '0;
      s3_meta_q <= '0;
      s4_meta_q <= '0;
    end else if (adv) begin
      s1_meta_q <= s1_meta_d;
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s3_meta_d;
      s4_meta_q <= s3_meta_q;
    end
  end

  // Divider: one quotient bit per stage.
  logic [QW-1:0] quo_x, quo_y;
  meta_t         dv_meta;

  cps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .num_x_i (s4_num_x_q),
    .num_y_i (s4_num_y_q),
    .den_i   (s4_den_q),
    .meta_i  (s4_meta_q),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .meta_o  (dv_meta)
  );

  // Output stage: pick the endpoint or apply the signed offset to A.
  logic signed [WW-1:0] ax_fx, ay_fx, bx_fx, by_fx, qx_w, qy_w, fx, fy;
  out_t                 out_d;

  always_comb begin
    ax_fx = WW'(dv_meta.ax) <<< FRAC_BITS;
    ay_fx = WW'(dv_meta.ay) <<< FRAC_BITS;
    bx_fx = WW'(dv_meta.bx) <<< FRAC_BITS;
    by_fx = WW'(dv_meta.by) <<< FRAC_BITS;
    qx_w  = WW'(quo_x);
    qy_w  = WW'(quo_y);
    case (dv_meta.region)
      RegionInterior: begin
        fx = dv_meta.neg_x ? (ax_fx - qx_w) : (ax_fx + qx_w);
        fy = dv_meta.neg_y ? (ay_fx - qy_w) : (ay_fx + qy_w);
      end
      RegionEnd: begin
        fx = bx_fx;
        fy = by_fx;
      end
      default: begin
        fx = ax_fx;
        fy = ay_fx;
      end
    endcase
    out_d.foot_x = fx[OUT_BITS-1:0];
    out_d.foot_y = fy[OUT_BITS-1:0];
    out_d.region = dv_meta.region;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= dv_meta.valid;
    end
  end

endmodule

/* hdl/cps_checker.sv */
// Port-level checker for the closest point block and its bind statement.
`timescale 1ns / 1ps
`include "closest_point_on_segment_defines.svh"

module cps_checker import cps_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled result holds until it is taken.
  `CPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // The pipeline takes an item exactly when its output register can move.
  `CPS_ASSERT_NOW(a_ready_follows, 1'b1, in_ready_o == (!out_valid_o || out_ready_i))

  // Clamped and degenerate results are endpoints, so they have no fraction.
  `CPS_ASSERT_NOW(a_endpoint_whole,
                  out_valid_o && (out_data_o.region != RegionInterior),
                  (out_data_o.foot_x[FRAC_BITS-1:0] == '0) &&
                  (out_data_o.foot_y[FRAC_BITS-1:0] == '0))

endmodule

bind closest_point_on_segment cps_checker u_cps_checker (.*);

/* bench/closest_point_on_segment_tb.sv */
// Self-checking testbench for the closest point on a line segment pipeline.
`timescale 1ns / 1ps

module closest_point_on_segment_tb;
  import cps_pkg::*;

  localparam int LATENCY   = COORD_BITS + FRAC_BITS + 5;
  localparam int MAX_CYCLE = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  // Expected foot points, oldest first.
  out_t foot_queue[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_cycles;
  int  n_errors;
  longint cycle_count;

  closest_point_on_segment u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Computes the nearest point of segment AB to P, in Q16.16 with a region code.
  function automatic out_t project_point(in_t it);
    longint px, py, ax, ay, bx, by, dx, dy, d1, d2, len2;
    logic [127:0] num_x, num_y, q_x, q_y;
    logic [63:0] fx, fy;
    out_t r;
    px = it.point_x; py = it.point_y;
    ax = it.start_x; ay = it.start_y;
    bx = it.end_x;   by = it.end_y;
    dx = bx - ax; dy = by - ay;
    d1 = (px - ax) * dx + (py - ay) * dy;
    d2 = (bx - px) * dx + (by - py) * dy;
    if (dx == 0 && dy == 0) begin
      fx = ax <<< FRAC_BITS; fy = ay <<< FRAC_BITS; r.region = RegionZero;
    end else if (d1 < 0) begin
      fx = ax <<< FRAC_BITS; fy = ay <<< FRAC_BITS; r.region = RegionStart;
    end else if (d2 < 0) begin
      fx = bx <<< FRAC_BITS; fy = by <<< FRAC_BITS; r.region = RegionEnd;
    end else begin
      len2 = dx * dx + dy * dy;
      // Magnitudes are exact in 128 bits; the sign of each delta is reapplied.
      num_x = (128'(dx < 0 ? -dx : dx) * 128'(d1)) << FRAC_BITS;
      num_y = (128'(dy < 0 ? -dy : dy) * 128'(d1)) << FRAC_BITS;
      q_x = num_x / 128'(len2);
      q_y = num_y / 128'(len2);
      fx = 64'(ax <<< FRAC_BITS);
      fy = 64'(ay <<< FRAC_BITS);
      fx = (dx < 0) ? fx - q_x[63:0] : fx + q_x[63:0];
      fy = (dy < 0) ? fy - q_y[63:0] : fy + q_y[63:0];
      r.region = RegionInterior;
    end
    r.foot_x = fx[31:0];
    r.foot_y = fy[31:0];
    return r;
  endfunction

  // Offers one item and waits until it is accepted. Valid stays high after the
  // accept so that items can follow back to back; idle cycles drop it.
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    foot_queue.push_back(project_point(it));
    @(negedge clk_i);
  endtask

  function automatic in_t make_item(int px, int py, int ax, int ay, int bx, int by);
    in_t it;
    it.point_x = 16'(px); it.point_y = 16'(py);
    it.start_x = 16'(ax); it.start_y = 16'(ay);
    it.end_x   = 16'(bx); it.end_y   = 16'(by);
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int span;
    it = in_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(5))
      0: begin
        // Short segments near the origin give readable fractions.
        span = 1 << $urandom_range(2, 15);
        it.start_x = 16'($urandom_range(span) - span / 2);
        it.start_y = 16'($urandom_range(span) - span / 2);
        it.end_x   = 16'($urandom_range(span) - span / 2);
        it.end_y   = 16'($urandom_range(span) - span / 2);
        it.point_x = 16'($urandom_range(2 * span) - span);
        it.point_y = 16'($urandom_range(2 * span) - span);
      end
      1: begin
        it.end_x = it.start_x;
        if ($urandom_range(1)) it.end_y = it.start_y;
      end
      2: it.end_y = it.start_y;
      3: begin
        // Point placed between the endpoints keeps the projection interior.
        it.point_x = 16'((int'(it.start_x) + int'(it.end_x)) / 2);
        it.point_y = 16'((int'(it.start_y) + int'(it.end_y)) / 2);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Compares each delivered result with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (foot_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        n_errors++;
      end else begin
        want = foot_queue.pop_front();
        if (out_data_o.foot_x !== want.foot_x) begin
          $display("%0t: foot_x expected %h actual %h", $time, want.foot_x,
                   out_data_o.foot_x);
          n_errors++;
        end
        if (out_data_o.foot_y !== want.foot_y) begin
          $display("%0t: foot_y expected %h actual %h", $time, want.foot_y,
                   out_data_o.foot_y);
          n_errors++;
        end
        if (out_data_o.region !== want.region) begin
          $display("%0t: region expected %0d actual %0d", $time, want.region,
                   out_data_o.region);
          n_errors++;
        end
      end
    end
  end

  // Receiver ready, with random stalls and a counted hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("FAIL closest_point_on_segment");
      $finish;
    end
  end

  // Stops offering items and waits until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (foot_queue.size() != 0) @(negedge clk_i);
  endtask

  // Corners of the field ranges, every region and the exact endpoint cases.
  task automatic test_directed();
    send_item(make_item(5, 5, 0, 0, 10, 0));
    send_item(make_item(-5, 3, 0, 0, 10, 0));
    send_item(make_item(15, 3, 0, 0, 10, 0));
    send_item(make_item(7, 7, 3, 3, 3, 3));
    send_item(make_item(0, 9, 0, 0, 10, 0));
    send_item(make_item(10, -9, 0, 0, 10, 0));
    send_item(make_item(1, 0, 0, 0, 3, 3));
    send_item(make_item(2, 1, 7, 7, 0, 0));
    send_item(make_item(0, 0, -32768, -32768, 32767, 32767));
    send_item(make_item(32767, -32768, -32768, 32767, 32767, -32768));
    send_item(make_item(-32768, -32768, 32767, 32767, -32768, -32768));
    send_item(make_item(32767, 32767, -32768, -32768, -32768, -32768));
    send_item(make_item(0, 1, -32768, 0, 32767, 0));
    send_item(make_item(1, 2, 0, -32768, 0, 32767));
    send_item(make_item(-1, -1, 32767, -32768, -32768, 32767));
    send_item(make_item(32767, 0, 0, 0, -1, 1));
    send_item(make_item(100, 50, -3, 7, 11, -13));
    send_item(make_item(-32768, 32767, 32767, 32767, -32768, 32767));
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(random_item());
  endtask

  // Receiver stalls long enough for the pipeline to fill and block the input.
  task automatic test_backpressure();
    hold_off_cycles = 3 * LATENCY;
    test_random(80);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    n_errors      = 0;
    cycle_count   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    send_idle_pct = 16;
    recv_idle_pct = 76;
    test_random(350);
    // The sender pauses here until every expected result has arrived.
    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 16;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(350);

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && foot_queue.size() == 0) begin
      $display("PASS closest_point_on_segment");
    end else begin
      $display("FAIL closest_point_on_segment");
    end
    $finish;
  end

endmodule
